>>> src/crsf_pkg.sv
// ----------------------------------------------------------------------------
// crsf_pkg
// Shared constants, state type and helper functions of the RC frame parser.
// ----------------------------------------------------------------------------
package crsf_pkg;

  localparam int WINDOW_BYTES = 64;
  localparam int WIN_AW       = $clog2(WINDOW_BYTES);
  localparam int FILL_W       = WIN_AW + 1;

  localparam logic [7:0]  SYNC_BYTE  = 8'hC8;
  localparam logic [7:0]  RC_TYPE    = 8'h16;
  localparam logic [7:0]  CRC_POLY   = 8'hD5;
  localparam logic [7:0]  RC_FLEN    = 8'd24;   // type + 22 payload bytes + crc
  localparam logic [7:0]  MIN_FLEN   = 8'd2;
  localparam logic [7:0]  MAX_FLEN   = 8'd62;
  localparam logic [10:0] CH_MASK    = 11'h7FF;
  localparam logic [11:0] PULSE_MID  = 12'd1500;
  localparam logic [11:0] STICK_MID  = 12'd992;

  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_TICK  = 2'd1,
    OP_ERROR = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    CFG_OUT0_CH  = 3'd0,
    CFG_OUT1_CH  = 3'd1,
    CFG_MIN_US   = 3'd2,
    CFG_MAX_US   = 3'd3,
    CFG_CENTER   = 3'd4,
    CFG_TIMEOUT  = 3'd5
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRITE,
    ST_CHECK,
    ST_SYNC,
    ST_LEN,
    ST_CRC,
    ST_CMP,
    ST_UNP0,
    ST_UNP1,
    ST_UNP2,
    ST_UNP3,
    ST_FIN,
    ST_FAILSAFE,
    ST_RESULT
  } state_e;

  function automatic logic [7:0] crc8_step(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    for (int b = 0; b < 8; b++) begin
      r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    end
    return r;
  endfunction

  function automatic logic [11:0] clamp_us(input logic [11:0] v, input logic [11:0] lo,
                                           input logic [11:0] hi);
    logic [11:0] r;
    r = (v < lo) ? lo : v;
    r = (r > hi) ? hi : r;
    return r;
  endfunction

  // (t-992)*5/8+1500, quotient truncated toward zero
  function automatic logic [11:0] stick_to_us(input logic [10:0] t);
    logic signed [15:0] d;
    logic signed [15:0] m;
    logic signed [15:0] q;
    d = $signed({5'd0, t}) - $signed({4'd0, STICK_MID});
    m = d * 16'sd5;
    q = (m < 0) ? ((m + 16'sd7) >>> 3) : (m >>> 3);
    return 12'(q + $signed({4'd0, PULSE_MID}));
  endfunction

endpackage

>>> src/crsf_rc_frame_to_servo_pulse.sv
// ----------------------------------------------------------------------------
// crsf_rc_frame_to_servo_pulse
// Frame hunter over a circular byte window, CRC check, RC channel unpack and
// servo pulse outputs with failsafe centering.
// ----------------------------------------------------------------------------
// Flow: a tick, link error or idle word passes the finish and failsafe states to
// its result. A byte is written to the window and then scanned; per scan position
// a header is read, a CRC pass reads one window byte per cycle through the memory
// read port, and an RC frame is unpacked.
// Throughput: one word at a time; the next word is taken after the result.
// Reset: window empty, link down, outputs centered at 1500, config defaults.
module crsf_rc_frame_to_servo_pulse
  import crsf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [11:0] out0_us_o,
  output logic [11:0] out1_us_o,
  output logic        out0_changed_o,
  output logic        out1_changed_o,
  output logic        rc_frame_taken_o,
  output logic        link_up_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  logic [7:0] mem [WINDOW_BYTES];
  logic [7:0] rdata_q;
  logic [WIN_AW-1:0] raddr, waddr;
  logic wr_en;

  state_e state_q, state_d;
  logic [1:0]  op_q, op_d;
  logic [7:0]  byte_q, byte_d;
  logic [11:0] start0_q, start0_d, start1_q, start1_d;
  logic [WIN_AW-1:0] head_q, head_d;
  logic [FILL_W-1:0] fill_q, fill_d, idx_q, idx_d;
  logic [FILL_W-1:0] rem;
  logic [7:0]  flen_q, flen_d, crc_q, crc_d, type_q, type_d, b0_q, b0_d, b1_q, b1_d;
  logic [5:0]  k_q, k_d;
  logic        sync_q, sync_d, sel_q, sel_d, got_q, got_d;
  logic [11:0] cand0_q, cand0_d, cand1_q, cand1_d;
  logic [15:0] age_q, age_d;
  logic        link_q, link_d, cent_q, cent_d, taken_q, taken_d;
  logic [11:0] lvl0_q, lvl0_d, lvl1_q, lvl1_d;
  logic [4:0]  ch0_q, ch1_q;
  logic [11:0] min_q, max_q, ctr_q;
  logic [15:0] tmo_q;

  logic        ok0, ok1;
  logic [4:0]  cur_ch;
  logic [7:0]  bitpos;
  logic [7:0]  total;
  logic [23:0] wword;
  logic [10:0] stick;
  logic [11:0] center_cl;

  assign ok0 = (ch0_q != 5'd0) && (ch0_q <= 5'd16);
  assign ok1 = (ch1_q != 5'd0) && (ch1_q <= 5'd16);
  assign cur_ch = sel_q ? ch1_q : ch0_q;
  assign bitpos = 8'(4'(cur_ch - 5'd1)) * 8'd11;
  assign total  = flen_q + 8'd2;
  assign rem    = fill_q - idx_q;
  assign wword  = {rdata_q, b1_q, b0_q};
  assign stick  = 11'(wword >> bitpos[2:0]) & CH_MASK;
  assign center_cl = clamp_us(ctr_q, min_q, max_q);

  // window memory
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[waddr] <= byte_q;
    end
    rdata_q <= mem[raddr];
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (op_e'(opcode_i) == OP_BYTE) ? ST_WRITE : ST_FIN;
        end
      end
      ST_WRITE: state_d = ST_CHECK;
      ST_CHECK: state_d = (rem >= FILL_W'(4)) ? ST_SYNC : ST_FIN;
      ST_SYNC:  state_d = ST_LEN;
      ST_LEN: begin
        if (!sync_q || rdata_q < MIN_FLEN || rdata_q > MAX_FLEN) begin
          state_d = ST_CHECK;
        end else if (8'(rem) < rdata_q + 8'd2) begin
          state_d = ST_FIN;
        end else begin
          state_d = ST_CRC;
        end
      end
      ST_CRC: begin
        if (8'(k_q) == flen_q - 8'd2) begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        if (rdata_q == crc_q && type_q == RC_TYPE && flen_q == RC_FLEN) begin
          state_d = ST_UNP0;
        end else begin
          state_d = ST_CHECK;
        end
      end
      ST_UNP0: state_d = ST_UNP1;
      ST_UNP1: state_d = ST_UNP2;
      ST_UNP2: state_d = ST_UNP3;
      ST_UNP3: state_d = sel_q ? ST_CHECK : ST_UNP0;
      ST_FIN:      state_d = ST_FAILSAFE;
      ST_FAILSAFE: state_d = ST_RESULT;
      ST_RESULT: begin
        if (!out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    op_d = op_q;  byte_d = byte_q;  start0_d = start0_q;  start1_d = start1_q;
    head_d = head_q;  fill_d = fill_q;  idx_d = idx_q;  flen_d = flen_q;
    crc_d = crc_q;  type_d = type_q;  b0_d = b0_q;  b1_d = b1_q;  k_d = k_q;
    sync_d = sync_q;  sel_d = sel_q;  got_d = got_q;
    cand0_d = cand0_q;  cand1_d = cand1_q;  age_d = age_q;  link_d = link_q;
    cent_d = cent_q;  taken_d = taken_q;  lvl0_d = lvl0_q;  lvl1_d = lvl1_q;
    raddr = head_q + idx_q[WIN_AW-1:0];
    waddr = head_q + fill_q[WIN_AW-1:0];
    wr_en = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d = opcode_i;  byte_d = rx_byte_i;
          start0_d = lvl0_q;  start1_d = lvl1_q;
          taken_d = 1'b0;  got_d = 1'b0;  idx_d = '0;
        end
      end
      ST_WRITE: begin
        wr_en = 1'b1;
        // full window: drop the oldest byte
        if (fill_q == FILL_W'(WINDOW_BYTES)) begin
          head_d = head_q + WIN_AW'(1);
          waddr  = head_q + WIN_AW'(1) + WIN_AW'(WINDOW_BYTES - 1);
          fill_d = FILL_W'(WINDOW_BYTES);
        end else begin
          fill_d = fill_q + FILL_W'(1);
        end
      end
      ST_CHECK: raddr = head_q + idx_q[WIN_AW-1:0];
      ST_SYNC: begin
        sync_d = (rdata_q == SYNC_BYTE);
        raddr  = head_q + idx_q[WIN_AW-1:0] + WIN_AW'(1);
      end
      ST_LEN: begin
        flen_d = rdata_q;
        crc_d  = '0;
        k_d    = '0;
        raddr  = head_q + idx_q[WIN_AW-1:0] + WIN_AW'(2);
        if (!sync_q || rdata_q < MIN_FLEN || rdata_q > MAX_FLEN) begin
          idx_d = idx_q + FILL_W'(1);
        end
      end
      ST_CRC: begin
        crc_d = crc8_step(crc_q ^ rdata_q);
        if (k_q == '0) begin
          type_d = rdata_q;
        end
        k_d   = k_q + 6'd1;
        raddr = head_q + idx_q[WIN_AW-1:0] + WIN_AW'(3) + k_q;
      end
      ST_CMP: begin
        sel_d = 1'b0;
        if (rdata_q != crc_q) begin
          idx_d = idx_q + FILL_W'(1);
        end else if (!(type_q == RC_TYPE && flen_q == RC_FLEN)) begin
          idx_d = idx_q + FILL_W'(total);
        end
      end
      ST_UNP0: raddr = head_q + idx_q[WIN_AW-1:0] + WIN_AW'(3) + WIN_AW'(bitpos[7:3]);
      ST_UNP1: begin
        b0_d  = rdata_q;
        raddr = head_q + idx_q[WIN_AW-1:0] + WIN_AW'(4) + WIN_AW'(bitpos[7:3]);
      end
      ST_UNP2: begin
        b1_d  = rdata_q;
        raddr = head_q + idx_q[WIN_AW-1:0] + WIN_AW'(5) + WIN_AW'(bitpos[7:3]);
      end
      ST_UNP3: begin
        if (sel_q) begin
          cand1_d = clamp_us(stick_to_us(stick), min_q, max_q);
          got_d   = 1'b1;
          idx_d   = idx_q + FILL_W'(total);
        end else begin
          cand0_d = clamp_us(stick_to_us(stick), min_q, max_q);
          sel_d   = 1'b1;
        end
      end
      ST_FIN: begin
        case (op_e'(op_q))
          OP_BYTE: begin
            head_d = head_q + idx_q[WIN_AW-1:0];
            fill_d = fill_q - idx_q;
            if (got_q) begin
              taken_d = 1'b1;  age_d = '0;  link_d = 1'b1;  cent_d = 1'b0;
              if (ok0) lvl0_d = cand0_q;
              if (ok1) lvl1_d = cand1_q;
            end
          end
          OP_TICK: begin
            if (link_q && age_q != 16'hFFFF) age_d = age_q + 16'd1;
          end
          OP_ERROR: begin
            if (!cent_q) begin
              if (ok0) lvl0_d = center_cl;
              if (ok1) lvl1_d = center_cl;
              cent_d = 1'b1;
            end
            link_d = 1'b0;
            fill_d = '0;
          end
          default: ;
        endcase
      end
      ST_FAILSAFE: begin
        if (link_q && age_q >= tmo_q && !cent_q) begin
          if (ok0) lvl0_d = center_cl;
          if (ok1) lvl1_d = center_cl;
          cent_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= '0;
      fill_q  <= '0;
      age_q   <= '0;
      link_q  <= 1'b0;
      cent_q  <= 1'b1;
      taken_q <= 1'b0;
      lvl0_q  <= PULSE_MID;
      lvl1_q  <= PULSE_MID;
      ch0_q   <= 5'd1;
      ch1_q   <= 5'd2;
      min_q   <= 12'd1000;
      max_q   <= 12'd2000;
      ctr_q   <= 12'd1500;
      tmo_q   <= 16'd500;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      fill_q  <= fill_d;
      age_q   <= age_d;
      link_q  <= link_d;
      cent_q  <= cent_d;
      taken_q <= taken_d;
      lvl0_q  <= lvl0_d;
      lvl1_q  <= lvl1_d;
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_OUT0_CH: ch0_q <= cfg_data_i[4:0];
          CFG_OUT1_CH: ch1_q <= cfg_data_i[4:0];
          CFG_MIN_US:  min_q <= cfg_data_i[11:0];
          CFG_MAX_US:  max_q <= cfg_data_i[11:0];
          CFG_CENTER:  ctr_q <= cfg_data_i[11:0];
          CFG_TIMEOUT: tmo_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;  byte_q <= byte_d;  start0_q <= start0_d;  start1_q <= start1_d;
    idx_q <= idx_d;  flen_q <= flen_d;  crc_q <= crc_d;  type_q <= type_d;
    b0_q <= b0_d;  b1_q <= b1_d;  k_q <= k_d;  sync_q <= sync_d;  sel_q <= sel_d;
    got_q <= got_d;  cand0_q <= cand0_d;  cand1_q <= cand1_d;
  end

  assign in_stall_o       = (state_q != ST_IDLE);
  assign out_valid_o      = (state_q == ST_RESULT);
  assign out0_us_o        = lvl0_q;
  assign out1_us_o        = lvl1_q;
  assign out0_changed_o   = (lvl0_q != start0_q);
  assign out1_changed_o   = (lvl1_q != start1_q);
  assign rc_frame_taken_o = taken_q;
  assign link_up_o        = link_q && !cent_q;

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench of the RC frame parser: drives link bytes, ticks and
// link errors, predicts every result word in a scoreboard and compares them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import crsf_pkg::*;

  localparam int WD_LIMIT = 20000;

  // ---------------------------------------------------------------------------
  // Scoreboard: behavioral copy of the parser and queue of expected words
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [11:0] us0;
    logic [11:0] us1;
    logic        chg0;
    logic        chg1;
    logic        taken;
    logic        up;
  } servo_word_t;

  class servo_scoreboard;
    logic [7:0]  win[WINDOW_BYTES];
    int          fill;
    int          age;
    bit          active;
    bit          centered;
    logic [11:0] lvl0, lvl1;
    logic [4:0]  ch0, ch1;
    logic [11:0] lo_us, hi_us, mid_us;
    logic [15:0] tmo;
    int          chan[16];
    servo_word_t pending[$];
    int          errors;
    int          checked;
    int          frames;

    function void init();
      fill = 0; age = 0; active = 0; centered = 1;
      lvl0 = 1500; lvl1 = 1500;
      ch0 = 1; ch1 = 2; lo_us = 1000; hi_us = 2000; mid_us = 1500; tmo = 500;
      errors = 0; checked = 0; frames = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [15:0] v);
      case (idx)
        CFG_OUT0_CH: ch0 = v[4:0];
        CFG_OUT1_CH: ch1 = v[4:0];
        CFG_MIN_US:  lo_us = v[11:0];
        CFG_MAX_US:  hi_us = v[11:0];
        CFG_CENTER:  mid_us = v[11:0];
        CFG_TIMEOUT: tmo = v;
        default: ;
      endcase
    endfunction

    function logic [11:0] clamp(int v);
      if (v < lo_us) v = lo_us;
      if (v > hi_us) v = hi_us;
      return v[11:0];
    endfunction

    function logic [7:0] crc_over(int start, int len);
      logic [7:0] c;
      c = 0;
      for (int k = 0; k < len; k++) begin
        c ^= win[start + k];
        for (int b = 0; b < 8; b++) c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
    endfunction

    function void unpack(int start);
      int bp, pos, t;
      logic [23:0] w;
      for (int c = 0; c < 16; c++) begin
        pos = c * 11;
        bp = pos / 8;
        w = win[start + bp];
        if (bp + 1 < 22) w[15:8] = win[start + bp + 1];
        if (bp + 2 < 22) w[23:16] = win[start + bp + 2];
        t = (w >> (pos % 8)) & 24'h7FF;
        chan[c] = ((t - 992) * 5) / 8 + 1500;
      end
    endfunction

    function bit scan();
      int i, flen;
      bit got;
      i = 0; got = 0;
      while (fill - i >= 4) begin
        flen = win[i + 1];
        if (win[i] != SYNC_BYTE || flen < 2 || flen > 62) begin
          i++;
          continue;
        end
        if (fill - i < flen + 2) break;
        if (crc_over(i + 2, flen - 1) != win[i + flen + 1]) begin
          i++;
          continue;
        end
        if (win[i + 2] == RC_TYPE && flen == 24) begin
          unpack(i + 3);
          got = 1;
        end
        i += flen + 2;
      end
      for (int k = 0; k < fill - i; k++) win[k] = win[k + i];
      fill -= i;
      return got;
    endfunction

    function void center();
      if (ch0 >= 1 && ch0 <= 16) lvl0 = clamp(mid_us);
      if (ch1 >= 1 && ch1 <= 16) lvl1 = clamp(mid_us);
    endfunction

    function void note_word(op_e op, logic [7:0] byte_in);
      logic [11:0] s0, s1;
      bit got;
      servo_word_t r;
      s0 = lvl0; s1 = lvl1; got = 0;
      case (op)
        OP_BYTE: begin
          if (fill >= WINDOW_BYTES) begin
            for (int k = 0; k < WINDOW_BYTES - 1; k++) win[k] = win[k + 1];
            fill = WINDOW_BYTES - 1;
          end
          win[fill] = byte_in;
          fill++;
          if (scan()) begin
            got = 1; age = 0; active = 1; centered = 0;
            if (ch0 >= 1 && ch0 <= 16) lvl0 = clamp(chan[ch0 - 1]);
            if (ch1 >= 1 && ch1 <= 16) lvl1 = clamp(chan[ch1 - 1]);
          end
        end
        OP_TICK: if (active && age < 65535) age++;
        OP_ERROR: begin
          if (!centered) begin
            center();
            centered = 1;
          end
          active = 0;
          fill = 0;
        end
        default: ;
      endcase
      if (active && age >= tmo && !centered) begin
        center();
        centered = 1;
      end
      r.us0 = lvl0; r.us1 = lvl1;
      r.chg0 = lvl0 != s0; r.chg1 = lvl1 != s1;
      r.taken = got; r.up = active && !centered;
      if (got) frames++;
      pending.push_back(r);
    endfunction

    task check_word(servo_word_t got);
      servo_word_t e;
      checked++;
      if (pending.size() == 0) begin
        report("unexpected word", 0, 0);
        return;
      end
      e = pending.pop_front();
      if (got.us0 != e.us0) report("out0_us", got.us0, e.us0);
      if (got.us1 != e.us1) report("out1_us", got.us1, e.us1);
      if (got.chg0 != e.chg0) report("out0_changed", got.chg0, e.chg0);
      if (got.chg1 != e.chg1) report("out1_changed", got.chg1, e.chg1);
      if (got.taken != e.taken) report("rc_frame_taken", got.taken, e.taken);
      if (got.up != e.up) report("link_up", got.up, e.up);
    endtask

    task report(string what, int got, int exp_v);
      errors++;
      if (errors <= 30)
        $display("MISMATCH word %0d %s: got %0d, expected %0d", checked, what, got, exp_v);
    endtask
  endclass

  // ---------------------------------------------------------------------------
  // Block hookup
  // ---------------------------------------------------------------------------
  logic        clk_i, rst_ni;
  logic        in_valid_i, in_stall_o;
  logic [1:0]  opcode_i;
  logic [7:0]  rx_byte_i;
  logic        out_valid_o, out_stall_i;
  logic [11:0] out0_us_o, out1_us_o;
  logic        out0_changed_o, out1_changed_o, rc_frame_taken_o, link_up_o;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;

  crsf_rc_frame_to_servo_pulse DUT (.*);

  servo_scoreboard sb;
  logic [7:0] frame_q[$];
  int  idle_pct;      // 0 during the no-idling stretch
  bit  hold_rx;       // long receiver hold-off
  int  quiet_cycles;

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Returns at the accepting edge; valid drops at a later falling edge.
  task automatic send_word(op_e op, logic [7:0] b);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 0;
      @(negedge clk_i);
    end
    in_valid_i <= 1;
    opcode_i   <= op;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_word(op, b);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (150) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [15:0] v);
    cfg_we_i <= 1; cfg_idx_i <= idx; cfg_data_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 0;
    sb.set_reg(idx, v);
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] crc_of(logic [7:0] q[$], int from);
    logic [7:0] c;
    c = 0;
    for (int k = from; k < q.size(); k++) begin
      c ^= q[k];
      for (int b = 0; b < 8; b++) c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  // Build a frame into frame_q; mode 0 RC frame with given channel values,
  // 1 other type, 2 RC frame with a broken crc.
  task automatic build_frame(int mode, int stick);
    logic [175:0] bits;
    int plen;
    frame_q = {};
    frame_q.push_back(SYNC_BYTE);
    if (mode == 1) begin
      plen = $urandom_range(0, 59);
      frame_q.push_back(plen + 2);
      frame_q.push_back(8'($urandom_range(0, 255) | 1));
      repeat (plen) frame_q.push_back($urandom_range(0, 255));
    end else begin
      for (int c = 0; c < 16; c++)
        bits[c*11 +: 11] = (stick < 0) ? 11'($urandom_range(0, 2047)) : 11'(stick);
      frame_q.push_back(24);
      frame_q.push_back(RC_TYPE);
      for (int k = 0; k < 22; k++) frame_q.push_back(bits[k*8 +: 8]);
    end
    frame_q.push_back(crc_of(frame_q, 2) ^ ((mode == 2) ? 8'h01 : 8'h00));
  endtask

  task automatic send_frame(int mode, int stick);
    build_frame(mode, stick);
    foreach (frame_q[k]) send_word(OP_BYTE, frame_q[k]);
  endtask

  task automatic random_setting(bit edges);
    write_reg(CFG_OUT0_CH, $urandom_range(0, 31) % 18);
    write_reg(CFG_OUT1_CH, $urandom_range(0, 31) % 18);
    write_reg(CFG_MIN_US, edges ? 500 : $urandom_range(500, 1500));
    write_reg(CFG_MAX_US, edges ? 2500 : $urandom_range(1200, 2500));
    write_reg(CFG_CENTER, $urandom_range(500, 2500));
    write_reg(CFG_TIMEOUT, $urandom_range(0, 3) == 0 ? $urandom_range(0, 3) :
                                                       $urandom_range(5, 60));
  endtask

  // ---------------------------------------------------------------------------
  // Receiver and watchdog
  // ---------------------------------------------------------------------------
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= hold_rx || ($urandom_range(99) < idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_word({out0_us_o, out1_us_o, out0_changed_o, out1_changed_o,
                     rc_frame_taken_o, link_up_o});
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || !rst_ni)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WD_LIMIT) begin
      $display("watchdog expired with %0d words outstanding", sb.pending.size());
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin
    hold_rx = 0;
    repeat (4000) @(negedge clk_i);
    hold_rx = 1;
    repeat (600) @(negedge clk_i);
    hold_rx = 0;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    sb = new();
    sb.init();
    idle_pct = 18;
    in_valid_i = 0; opcode_i = OP_NONE; rx_byte_i = 0;
    cfg_we_i = 0; cfg_idx_i = CFG_OUT0_CH; cfg_data_i = 0;
    rst_ni = 0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // Directed: stick extremes, other frame type, bad crc, ticks, error, idle op
    send_frame(0, 0);
    send_frame(0, 2047);
    send_frame(1, 0);
    send_frame(2, 992);
    send_word(OP_NONE, 8'hFF);
    repeat (3) send_word(OP_TICK, 0);
    send_word(OP_ERROR, 0);
    send_word(OP_BYTE, 8'h00);
    send_word(OP_BYTE, SYNC_BYTE);
    send_word(OP_ERROR, 0);
    drain();

    // Timeout at zero, min above max, channel sixteen and a channel above sixteen
    write_reg(CFG_TIMEOUT, 0);
    write_reg(CFG_MIN_US, 2500);
    write_reg(CFG_MAX_US, 500);
    write_reg(CFG_OUT0_CH, 16);
    write_reg(CFG_OUT1_CH, 31);
    write_reg(CFG_CENTER, 2500);
    send_frame(0, -1);
    send_word(OP_TICK, 0);
    drain();
    write_reg(CFG_TIMEOUT, 65535);
    random_setting(1);
    write_reg(CFG_TIMEOUT, 65535);

    // Random: mostly well-formed frames, plus noise, ticks, errors
    for (int phase = 0; phase < 6; phase++) begin
      idle_pct = (phase == 2) ? 0 : 18;
      for (int n = 0; n < 110; ) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin send_frame(0, -1); n += 26; end
          4: begin send_frame($urandom_range(1, 2), -1); n += 10; end
          5, 6: begin
            repeat ($urandom_range(1, 8)) send_word(OP_TICK, 0);
            n += 4;
          end
          7: begin
            repeat ($urandom_range(1, 6))
              send_word(OP_BYTE, $urandom_range(0, 3) == 0 ? SYNC_BYTE :
                                 8'($urandom_range(0, 255)));
            n += 3;
          end
          8: begin send_word(op_e'($urandom_range(2, 3)), $urandom_range(0, 255)); n++; end
          default: begin
            // first ten bytes of a frame, then one garbage byte
            build_frame(0, -1);
            for (int k = 0; k < 10; k++) send_word(OP_BYTE, frame_q[k]);
            send_word(OP_BYTE, $urandom_range(0, 255));
            n += 11;
          end
        endcase
      end
      drain();
      random_setting(phase == 4);
    end
    // Bytes that never form a frame, then an RC frame
    repeat (80) send_word(OP_BYTE, 8'h00);
    send_frame(0, -1);
    drain();

    $display("covered %0d words, %0d RC frames taken, six settings plus extremes",
             sb.checked, sb.frames);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("%0d mismatches, %0d words outstanding", sb.errors, sb.pending.size());
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

>>> crsf_rc_frame_to_servo_pulse.f
src/crsf_pkg.sv
src/crsf_rc_frame_to_servo_pulse.sv
bench/tb_top.sv
